@@ design/httc_pkg.sv @@
package httc_pkg;

   // Field widths
   localparam int TIME_W  = 64;
   localparam int TICK_W  = 32;
   localparam int CNT_W   = 6;
   localparam int REQ_W   = 136;
   localparam int RSP_W   = 40;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 1;

   // Register reset values
   localparam logic [TIME_W-1:0] TPS_RESET   = 64'd1000000;
   localparam logic [TICK_W-1:0] BATCH_RESET = 32'd800000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_BATCH_TICKS  = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ELAPSED,
      ST_DIV_TIME,
      ST_MUL_WHOLE,
      ST_MUL_PART,
      ST_ADD_FRAC,
      ST_DIV_SCALED,
      ST_ADD_TICKS,
      ST_ADD_PENDING,
      ST_BATCH,
      ST_RESP
   } state_type;

endpackage

@@ design/host_time_to_tick_converter.sv @@
// Host time to tick converter.
// The req_ channel carries one word per host time sample or clear request:
// req_tuser is the kind (0 sample, 1 clear), req_tdata the host count, its
// units-per-second rate and the read status. The rsp_ channel returns one
// word per request: the ticks released (capped at max_batch_ticks) and a
// fault flag. Configuration goes through csr_we/csr_index/csr_wdata; the user
// must write it only while no request is in flight, which is not enforced.
// One 66-bit adder is shared by every step under a small sequencer: two
// 64-step restoring divisions and two 64-step shift-add multiplications.
// A full conversion passes through every step before its result shows; a
// clear, a latching sample or a fault found by the first check goes straight
// from the check to the result, backwards time from the elapsed-time step.
// The block is not ready during the conversion nor while its result waits,
// and returns to ready in the cycle after rsp_tready takes the result, so
// one request is taken at a time. A stalled receiver simply holds the
// result in place and keeps the block from taking the next request.
// Reset is synchronous: it drops any request in flight, clears the
// converter state and restores the register reset values.
module host_time_to_tick_converter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] host_units, [127:64] units_rate, [128] read_ok, rest zero
   input  logic [httc_pkg::REQ_W-1:0]        req_tdata,
   // [0] kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] ticks_out, [32] status, rest zero
   output logic [httc_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_we,
   input  logic [httc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [httc_pkg::CSR_W-1:0]        csr_wdata
);

   httc_pkg::state_type state_ff, state_in;

   // Configuration and converter state
   logic [63:0] tps_ff, tps_in;
   logic [31:0] batch_ff, batch_in;
   logic        started_ff, started_in;
   logic [63:0] last_time_ff, last_time_in;
   logic [63:0] latched_rate_ff, latched_rate_in;
   logic [63:0] frac_ff, frac_in;
   logic [63:0] pending_ff, pending_in;

   // Latched request word
   logic        kind_ff, kind_in;
   logic [63:0] units_ff, units_in;
   logic [63:0] rate_ff, rate_in;
   logic        ok_ff, ok_in;

   // Working registers of the shared unit
   logic [63:0] q_ff, q_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic        ovf_ff, ovf_in;
   logic [httc_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // Result register
   logic [31:0] rsp_ticks_ff, rsp_ticks_in;
   logic        rsp_status_ff, rsp_status_in;

   // Shared adder
   logic [64:0] alu_a, alu_b;
   logic        alu_cin;
   logic [65:0] alu_sum;
   logic [64:0] rem_sh;
   logic        last_iter, carry64, div_ge, mul_ovf, input_bad, rate_diff;

   assign req_tready = (state_ff == httc_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == httc_pkg::ST_RESP);
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_ticks_ff};

   assign rem_sh    = {rem_ff, q_ff[63]};
   assign last_iter = (cnt_ff == {httc_pkg::CNT_W{1'b1}});
   assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b} + {65'd0, alu_cin};
   assign carry64   = alu_sum[64];
   assign div_ge    = alu_sum[65];
   assign mul_ovf   = alu_sum[65] | alu_sum[64];
   assign input_bad = (tps_ff == 64'd0) || !ok_ff || (rate_ff == 64'd0);
   assign rate_diff = (rate_ff != latched_rate_ff);

   // Select the operands of the shared adder
   always_comb begin
      alu_a   = 65'd0;
      alu_b   = 65'd0;
      alu_cin = 1'b0;
      unique case (state_ff)
         httc_pkg::ST_ELAPSED: begin
            alu_a   = {1'b0, units_ff};
            alu_b   = {1'b0, ~last_time_ff};
            alu_cin = 1'b1;
         end
         httc_pkg::ST_DIV_TIME, httc_pkg::ST_DIV_SCALED: begin
            alu_a   = rem_sh;
            alu_b   = {1'b1, ~rate_ff};
            alu_cin = 1'b1;
         end
         httc_pkg::ST_MUL_WHOLE, httc_pkg::ST_MUL_PART: begin
            alu_a = {acc_ff, 1'b0};
            alu_b = {1'b0, (q_ff[63] ? tps_ff : 64'd0)};
         end
         httc_pkg::ST_ADD_FRAC: begin
            alu_a = {1'b0, acc_ff};
            alu_b = {1'b0, frac_ff};
         end
         httc_pkg::ST_ADD_TICKS: begin
            alu_a = {1'b0, prod_ff};
            alu_b = {1'b0, q_ff};
         end
         httc_pkg::ST_ADD_PENDING: begin
            alu_a = {1'b0, pending_ff};
            alu_b = {1'b0, prod_ff};
         end
         httc_pkg::ST_BATCH: begin
            alu_a   = {1'b0, pending_ff};
            alu_b   = {1'b0, ~{32'd0, batch_ff}};
            alu_cin = 1'b1;
         end
         default: begin
            alu_a   = 65'd0;
            alu_b   = 65'd0;
            alu_cin = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         httc_pkg::ST_IDLE:
            if (req_tvalid) state_in = httc_pkg::ST_CHECK;
         httc_pkg::ST_CHECK:
            if (kind_ff || input_bad || !started_ff || rate_diff) begin
               state_in = httc_pkg::ST_RESP;
            end else begin
               state_in = httc_pkg::ST_ELAPSED;
            end
         httc_pkg::ST_ELAPSED:
            state_in = carry64 ? httc_pkg::ST_DIV_TIME : httc_pkg::ST_RESP;
         httc_pkg::ST_DIV_TIME:
            if (last_iter) state_in = httc_pkg::ST_MUL_WHOLE;
         httc_pkg::ST_MUL_WHOLE:
            if (last_iter) state_in = httc_pkg::ST_MUL_PART;
         httc_pkg::ST_MUL_PART:
            if (last_iter) state_in = httc_pkg::ST_ADD_FRAC;
         httc_pkg::ST_ADD_FRAC:
            state_in = (ovf_ff || carry64) ? httc_pkg::ST_RESP : httc_pkg::ST_DIV_SCALED;
         httc_pkg::ST_DIV_SCALED:
            if (last_iter) state_in = httc_pkg::ST_ADD_TICKS;
         httc_pkg::ST_ADD_TICKS:
            state_in = carry64 ? httc_pkg::ST_RESP : httc_pkg::ST_ADD_PENDING;
         httc_pkg::ST_ADD_PENDING:
            state_in = carry64 ? httc_pkg::ST_RESP : httc_pkg::ST_BATCH;
         httc_pkg::ST_BATCH:
            state_in = httc_pkg::ST_RESP;
         httc_pkg::ST_RESP:
            if (rsp_tready) state_in = httc_pkg::ST_IDLE;
         default:
            state_in = httc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and state updates
   always_comb begin
      tps_in          = tps_ff;
      batch_in        = batch_ff;
      started_in      = started_ff;
      last_time_in    = last_time_ff;
      latched_rate_in = latched_rate_ff;
      frac_in         = frac_ff;
      pending_in      = pending_ff;
      kind_in         = kind_ff;
      units_in        = units_ff;
      rate_in         = rate_ff;
      ok_in           = ok_ff;
      q_in            = q_ff;
      rem_in          = rem_ff;
      acc_in          = acc_ff;
      prod_in         = prod_ff;
      ovf_in          = ovf_ff;
      cnt_in          = cnt_ff;
      rsp_ticks_in    = rsp_ticks_ff;
      rsp_status_in   = rsp_status_ff;

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            httc_pkg::REG_TICKS_PER_SECOND: tps_in   = csr_wdata;
            httc_pkg::REG_MAX_BATCH_TICKS:  batch_in = csr_wdata[31:0];
            default:                        tps_in   = tps_ff;
         endcase
      end

      unique case (state_ff)
         httc_pkg::ST_IDLE: begin
            // hold the request word
            kind_in  = req_tuser;
            units_in = req_tdata[63:0];
            rate_in  = req_tdata[127:64];
            ok_in    = req_tdata[128];
         end
         httc_pkg::ST_CHECK: begin
            cnt_in        = '0;
            acc_in        = 64'd0;
            ovf_in        = 1'b0;
            rsp_ticks_in  = 32'd0;
            rsp_status_in = 1'b0;
            if (kind_ff) begin
               started_in      = 1'b0;
               last_time_in    = 64'd0;
               latched_rate_in = 64'd0;
               frac_in         = 64'd0;
               pending_in      = 64'd0;
            end else if (input_bad) begin
               rsp_status_in = 1'b1;
            end else if (!started_ff) begin
               last_time_in    = units_ff;
               latched_rate_in = rate_ff;
               frac_in         = 64'd0;
               started_in      = 1'b1;
            end else if (rate_diff) begin
               rsp_status_in = 1'b1;
            end
         end
         httc_pkg::ST_ELAPSED: begin
            // no borrow means time did not run backwards
            if (carry64) begin
               last_time_in = units_ff;
               q_in         = alu_sum[63:0];
               rem_in       = 64'd0;
            end else begin
               rsp_status_in = 1'b1;
            end
         end
         httc_pkg::ST_DIV_TIME, httc_pkg::ST_DIV_SCALED: begin
            // one restoring division step
            rem_in = div_ge ? alu_sum[63:0] : rem_sh[63:0];
            q_in   = {q_ff[62:0], div_ge};
            cnt_in = cnt_ff + {{(httc_pkg::CNT_W-1){1'b0}}, 1'b1};
         end
         httc_pkg::ST_MUL_WHOLE, httc_pkg::ST_MUL_PART: begin
            // one shift-add step, multiplier bits taken from the top
            acc_in = alu_sum[63:0];
            ovf_in = ovf_ff | mul_ovf;
            q_in   = {q_ff[62:0], 1'b0};
            cnt_in = cnt_ff + {{(httc_pkg::CNT_W-1){1'b0}}, 1'b1};
            if (state_ff == httc_pkg::ST_MUL_WHOLE && last_iter) begin
               prod_in = alu_sum[63:0];
               q_in    = rem_ff;
               acc_in  = 64'd0;
            end
         end
         httc_pkg::ST_ADD_FRAC: begin
            if (ovf_ff || carry64) begin
               rsp_status_in = 1'b1;
            end else begin
               q_in   = alu_sum[63:0];
               rem_in = 64'd0;
            end
         end
         httc_pkg::ST_ADD_TICKS: begin
            // the new fraction stands even if pending later overflows
            if (carry64) begin
               rsp_status_in = 1'b1;
            end else begin
               prod_in = alu_sum[63:0];
               frac_in = rem_ff;
            end
         end
         httc_pkg::ST_ADD_PENDING: begin
            if (carry64) begin
               rsp_status_in = 1'b1;
            end else begin
               pending_in = alu_sum[63:0];
            end
         end
         httc_pkg::ST_BATCH: begin
            // release at most one batch
            if (carry64) begin
               rsp_ticks_in = batch_ff;
               pending_in   = alu_sum[63:0];
            end else begin
               rsp_ticks_in = pending_ff[31:0];
               pending_in   = 64'd0;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control and converter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= httc_pkg::ST_IDLE;
         tps_ff          <= httc_pkg::TPS_RESET;
         batch_ff        <= httc_pkg::BATCH_RESET;
         started_ff      <= 1'b0;
         last_time_ff    <= 64'd0;
         latched_rate_ff <= 64'd0;
         frac_ff         <= 64'd0;
         pending_ff      <= 64'd0;
         cnt_ff          <= '0;
         ovf_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tps_ff          <= tps_in;
         batch_ff        <= batch_in;
         started_ff      <= started_in;
         last_time_ff    <= last_time_in;
         latched_rate_ff <= latched_rate_in;
         frac_ff         <= frac_in;
         pending_ff      <= pending_in;
         cnt_ff          <= cnt_in;
         ovf_ff          <= ovf_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      units_ff      <= units_in;
      rate_ff       <= rate_in;
      ok_ff         <= ok_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_ticks_ff  <= rsp_ticks_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
